>>> rtl/core/priority_task_queue_with_cancel_defines.svh
// -----------------------------------------------------------------------------
// Priority task queue defines
// Assertion macros used by the checker of the priority task queue.
// -----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_QUEUE_WITH_CANCEL_DEFINES_SVH
`define PRIORITY_TASK_QUEUE_WITH_CANCEL_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define PTQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante
`define PTQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ptq_pkg.sv
// -----------------------------------------------------------------------------
// Priority task queue package
// Codes, field widths, defaults and shared types of the priority task queue.
// -----------------------------------------------------------------------------
package ptq_pkg;

	// Default sizes
	localparam int PTQ_LEVELS      = 5;
	localparam int PTQ_QUEUE_DEPTH = 16;
	localparam int PTQ_MAX_RUNNING = 8;

	// Priority clamp range
	localparam int PRIO_MIN = -2;
	localparam int PRIO_MAX = 2;

	// Field widths
	localparam int ID_W      = 32;
	localparam int OP_W      = 3;
	localparam int PRIO_W    = 4;
	localparam int ST_W      = 3;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;

	// Operation codes
	localparam logic [OP_W-1:0] OP_SUBMIT   = 3'd0;
	localparam logic [OP_W-1:0] OP_DISPATCH = 3'd1;
	localparam logic [OP_W-1:0] OP_COMPLETE = 3'd2;
	localparam logic [OP_W-1:0] OP_CANCEL   = 3'd3;
	localparam logic [OP_W-1:0] OP_FLUSH    = 3'd4;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [ST_W-1:0] ST_RUNNING   = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
	localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;
	localparam logic [ST_W-1:0] ST_BUSY      = 3'd5;

	// Running set port controls
	typedef struct packed {
		logic rd;
		logic set;
		logic clr;
	} run_ctl_t;

endpackage

>>> rtl/core/ptq_run_set.sv
// -----------------------------------------------------------------------------
// Running set
// Ids of dispatched tasks: valid flags in flops, ids in a small memory with a
// registered read port, and a first-free-slot encoder for inserts.
// -----------------------------------------------------------------------------
module ptq_run_set import ptq_pkg::*; #(
	parameter int MAX_RUNNING = PTQ_MAX_RUNNING,
	parameter int RW          = (MAX_RUNNING > 1) ? $clog2(MAX_RUNNING) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  run_ctl_t        ctl,
	input  logic [RW-1:0]   rd_idx,
	input  logic [RW-1:0]   wr_idx,
	input  logic [ID_W-1:0] wr_id,
	output logic [ID_W-1:0] rd_id,
	output logic            rd_valid,
	output logic            free_ok,
	output logic [RW-1:0]   free_idx
);

	logic [ID_W-1:0]        id_mem [MAX_RUNNING];
	logic [MAX_RUNNING-1:0] valid_q;

	// Write and read the id memory
	always_ff @(posedge clk) begin
		if (ctl.set) begin
			id_mem[wr_idx] <= wr_id;
		end
		if (ctl.rd) begin
			rd_id <= id_mem[rd_idx];
		end
	end

	// Track entry valid flags and register the flag with each read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (ctl.set) begin
				valid_q[wr_idx] <= 1'b1;
			end else if (ctl.clr) begin
				valid_q[wr_idx] <= 1'b0;
			end
			if (ctl.rd) begin
				rd_valid <= valid_q[rd_idx];
			end
		end
	end

	// Pick the lowest free entry
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = MAX_RUNNING - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_ok  = 1'b1;
				free_idx = RW'(i);
			end
		end
	end

endmodule

>>> rtl/core/priority_task_queue_with_cancel.sv
// -----------------------------------------------------------------------------
// Priority task queue with cancel
// Multi-level FIFO task queue: submit, dispatch, complete, cancel and flush
// requests run under a small sequencer around one shared 32-bit id compare.
//
//   channel  dir  signals                       content
//   s_axis   in   tvalid tready tdata tuser     request: op, prio, task_id
//   m_axis   out  tvalid tready tdata tuser     response: result_id, status
//
// One request at a time; tready is high only while the sequencer idles.
// Submit, flush and unknown ops answer straight from decode; complete scans the
// running set; dispatch reads the head id of the most urgent level, then scans
// the running set; cancel scans the running set, then searches queued ids level
// by level and moves later ids down after a removal. Each id compared costs one
// read of the FIFO memory or the running-set memory plus a compare on the
// shared comparator.
// Reset clears counts, heads, running flags and the id counter at once.
// A stalled response holds the sequencer before its return to idle.
// -----------------------------------------------------------------------------
module priority_task_queue_with_cancel import ptq_pkg::*; #(
	parameter int LEVELS      = PTQ_LEVELS,
	parameter int QUEUE_DEPTH = PTQ_QUEUE_DEPTH,
	parameter int MAX_RUNNING = PTQ_MAX_RUNNING
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // prio[3:0], task_id[35:4], zero[39:36]
	input  logic [OP_W-1:0]      s_axis_tuser,  // op[2:0]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // result_id[31:0]
	output logic [ST_W-1:0]      m_axis_tuser   // status[2:0]
);

	localparam int LW    = $clog2(LEVELS);
	localparam int QW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int PW    = CW + 1;
	localparam int DEPTH = LEVELS * QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = (MAX_RUNNING > 1) ? $clog2(MAX_RUNNING) : 1;
	localparam int RW1   = $clog2(MAX_RUNNING + 1);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_DECODE = 10'b00_0000_0010,
		S_DRD    = 10'b00_0000_0100,
		S_DKEY   = 10'b00_0000_1000,
		S_RRD    = 10'b00_0001_0000,
		S_RCMP   = 10'b00_0010_0000,
		S_QSEL   = 10'b00_0100_0000,
		S_QCMP   = 10'b00_1000_0000,
		S_SRD    = 10'b01_0000_0000,
		S_SWR    = 10'b10_0000_0000
	} state_t;

	state_t            state_q;
	logic              resp_q;
	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   tid_q;
	logic [ID_W-1:0]   key_q;
	logic [LW-1:0]     lvl_q;
	logic [CW-1:0]     k_q;
	logic [RW1-1:0]    idx_q;
	logic [ID_W-1:0]   id_ctr_q;
	logic [CW-1:0]     cnt_q  [LEVELS];
	logic [QW-1:0]     head_q [LEVELS];
	logic [ID_W-1:0]   res_id_q;
	logic [ST_W-1:0]   res_st_q;
	logic              out_valid_q;
	logic [ID_W-1:0]   out_id_q;
	logic [ST_W-1:0]   out_st_q;

	logic [ID_W-1:0]   fifo_mem [DEPTH];
	logic [ID_W-1:0]   fifo_rd;
	logic              fifo_we;
	logic              fifo_re;
	logic [AW-1:0]     fifo_waddr;
	logic [AW-1:0]     fifo_raddr;
	logic [ID_W-1:0]   fifo_wdata;

	run_ctl_t          run_ctl;
	logic [RW-1:0]     run_wr_idx;
	logic [ID_W-1:0]   run_rd_id;
	logic              run_rd_valid;
	logic              run_free_ok;
	logic [RW-1:0]     run_free_idx;

	logic [OP_W-1:0]   in_op;
	logic signed [PRIO_W-1:0] in_prio;
	logic [ID_W-1:0]   in_tid;
	logic [2:0]        prio_cl;
	logic [LW-1:0]     lvl_in;
	logic [CW-1:0]     cnt_sel;
	logic [QW-1:0]     head_sel;
	logic [QW-1:0]     head_inc;
	logic [ID_W-1:0]   nxt_id;
	logic              sub_full;
	logic              run_miss;
	logic              any_ne;
	logic [LW-1:0]     first_lvl;
	logic [ID_W-1:0]   cmp_a;
	logic              cmp_eq;
	logic              hit;
	logic [CW-1:0]     k_inc;
	logic              in_acc;

	// Map a position relative to the level head to a memory address
	function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] lvl,
		input logic [QW-1:0] head, input logic [CW-1:0] k);
		logic [PW-1:0] pos;
		pos = PW'(head) + PW'(k);
		if (pos >= PW'(QUEUE_DEPTH)) begin
			pos = pos - PW'(QUEUE_DEPTH);
		end
		return AW'(32'(lvl) * QUEUE_DEPTH) + AW'(pos);
	endfunction

	// Unpack the request and clamp its priority to a level
	assign in_op   = s_axis_tuser;
	assign in_prio = s_axis_tdata[3:0];
	assign in_tid  = s_axis_tdata[35:4];
	assign in_acc  = s_axis_tvalid && s_axis_tready;

	always_comb begin
		if (in_prio < PRIO_MIN) begin
			prio_cl = 3'd0;
		end else if (in_prio > PRIO_MAX) begin
			prio_cl = 3'(PRIO_MAX - PRIO_MIN);
		end else begin
			prio_cl = 3'(int'(in_prio) - PRIO_MIN);
		end
		if (32'(prio_cl) > LEVELS - 1) begin
			lvl_in = LW'(LEVELS - 1);
		end else begin
			lvl_in = LW'(prio_cl);
		end
	end

	// Look up the selected level and find the most urgent non-empty one
	assign cnt_sel  = cnt_q[lvl_q];
	assign head_sel = head_q[lvl_q];
	assign head_inc = (head_sel == QW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + QW'(1);
	assign sub_full = cnt_sel >= CW'(QUEUE_DEPTH);
	assign nxt_id   = (id_ctr_q + ID_W'(1) == '0) ? ID_W'(1) : id_ctr_q + ID_W'(1);
	assign k_inc    = k_q + CW'(1);

	always_comb begin
		any_ne    = 1'b0;
		first_lvl = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				any_ne    = 1'b1;
				first_lvl = LW'(i);
			end
		end
	end

	// Shared id comparator
	assign cmp_a    = (state_q == S_QCMP) ? fifo_rd : run_rd_id;
	assign cmp_eq   = (cmp_a == key_q);
	assign hit      = run_rd_valid && cmp_eq;
	assign run_miss = (idx_q == RW1'(MAX_RUNNING));

	// Drive the memory ports; hold them quiet while a response waits
	always_comb begin
		fifo_we    = 1'b0;
		fifo_re    = 1'b0;
		fifo_waddr = '0;
		fifo_raddr = '0;
		fifo_wdata = fifo_rd;
		run_ctl    = '0;
		if (!resp_q) begin
			case (state_q)
				S_DECODE: begin
					if (op_q == OP_SUBMIT && !sub_full) begin
						fifo_we    = 1'b1;
						fifo_waddr = slot_addr(lvl_q, head_sel, cnt_sel);
						fifo_wdata = nxt_id;
					end
				end
				S_DRD: begin
					fifo_re    = 1'b1;
					fifo_raddr = slot_addr(lvl_q, head_sel, '0);
				end
				S_RRD: begin
					if (!run_miss) begin
						run_ctl.rd = 1'b1;
					end else if (op_q == OP_DISPATCH && run_free_ok) begin
						run_ctl.set = 1'b1;
					end
				end
				S_RCMP: begin
					if (hit && op_q == OP_COMPLETE) begin
						run_ctl.clr = 1'b1;
					end
				end
				S_QSEL: begin
					if (k_q < cnt_sel) begin
						fifo_re    = 1'b1;
						fifo_raddr = slot_addr(lvl_q, head_sel, k_q);
					end
				end
				S_SRD: begin
					if (k_inc < cnt_sel) begin
						fifo_re    = 1'b1;
						fifo_raddr = slot_addr(lvl_q, head_sel, k_inc);
					end
				end
				S_SWR: begin
					fifo_we    = 1'b1;
					fifo_waddr = slot_addr(lvl_q, head_sel, k_q);
				end
				default: begin
				end
			endcase
		end
	end

	assign run_wr_idx = run_ctl.set ? run_free_idx : idx_q[RW-1:0];

	// Level FIFO storage
	always_ff @(posedge clk) begin
		if (fifo_we) begin
			fifo_mem[fifo_waddr] <= fifo_wdata;
		end
		if (fifo_re) begin
			fifo_rd <= fifo_mem[fifo_raddr];
		end
	end

	ptq_run_set #(
		.MAX_RUNNING (MAX_RUNNING),
		.RW          (RW)
	) u_run_set (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (run_ctl),
		.rd_idx   (idx_q[RW-1:0]),
		.wr_idx   (run_wr_idx),
		.wr_id    (key_q),
		.rd_id    (run_rd_id),
		.rd_valid (run_rd_valid),
		.free_ok  (run_free_ok),
		.free_idx (run_free_idx)
	);

	// Capture request fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= in_op;
			tid_q <= in_tid;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			resp_q   <= 1'b0;
			id_ctr_q <= '0;
			lvl_q    <= '0;
			k_q      <= '0;
			idx_q    <= '0;
			key_q    <= '0;
			res_id_q <= '0;
			res_st_q <= ST_OK;
			for (int i = 0; i < LEVELS; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
			end
		end else if (resp_q) begin
			// Hand the finished response to the output register
			if (!out_valid_q || m_axis_tready) begin
				resp_q  <= 1'b0;
				state_q <= S_IDLE;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						lvl_q   <= lvl_in;
						key_q   <= in_tid;
						idx_q   <= '0;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (op_q)
						OP_SUBMIT: begin
							resp_q <= 1'b1;
							if (sub_full) begin
								res_id_q <= '0;
								res_st_q <= ST_FULL;
							end else begin
								id_ctr_q     <= nxt_id;
								cnt_q[lvl_q] <= cnt_sel + CW'(1);
								res_id_q     <= nxt_id;
								res_st_q     <= ST_OK;
							end
						end
						OP_DISPATCH: begin
							if (!any_ne) begin
								res_id_q <= '0;
								res_st_q <= ST_EMPTY;
								resp_q   <= 1'b1;
							end else begin
								lvl_q   <= first_lvl;
								state_q <= S_DRD;
							end
						end
						OP_COMPLETE, OP_CANCEL: begin
							state_q <= S_RRD;
						end
						OP_FLUSH: begin
							for (int i = 0; i < LEVELS; i++) begin
								cnt_q[i] <= '0;
							end
							res_id_q <= tid_q;
							res_st_q <= ST_OK;
							resp_q   <= 1'b1;
						end
						default: begin
							res_id_q <= tid_q;
							res_st_q <= ST_NOT_FOUND;
							resp_q   <= 1'b1;
						end
					endcase
				end
				S_DRD: begin
					state_q <= S_DKEY;
				end
				S_DKEY: begin
					key_q   <= fifo_rd;
					state_q <= S_RRD;
				end
				S_RRD: begin
					if (!run_miss) begin
						state_q <= S_RCMP;
					end else begin
						case (op_q)
							OP_DISPATCH: begin
								resp_q <= 1'b1;
								if (run_free_ok) begin
									head_q[lvl_q] <= head_inc;
									cnt_q[lvl_q]  <= cnt_sel - CW'(1);
									res_id_q      <= key_q;
									res_st_q      <= ST_OK;
								end else begin
									res_id_q <= '0;
									res_st_q <= ST_BUSY;
								end
							end
							OP_CANCEL: begin
								lvl_q   <= '0;
								k_q     <= '0;
								state_q <= S_QSEL;
							end
							default: begin
								res_id_q <= tid_q;
								res_st_q <= ST_NOT_FOUND;
								resp_q   <= 1'b1;
							end
						endcase
					end
				end
				S_RCMP: begin
					if (hit) begin
						resp_q <= 1'b1;
						case (op_q)
							OP_DISPATCH: begin
								head_q[lvl_q] <= head_inc;
								cnt_q[lvl_q]  <= cnt_sel - CW'(1);
								res_id_q      <= key_q;
								res_st_q      <= ST_OK;
							end
							OP_CANCEL: begin
								res_id_q <= tid_q;
								res_st_q <= ST_RUNNING;
							end
							default: begin
								res_id_q <= tid_q;
								res_st_q <= ST_OK;
							end
						endcase
					end else begin
						idx_q   <= idx_q + RW1'(1);
						state_q <= S_RRD;
					end
				end
				S_QSEL: begin
					if (k_q < cnt_sel) begin
						state_q <= S_QCMP;
					end else if (lvl_q == LW'(LEVELS - 1)) begin
						res_id_q <= tid_q;
						res_st_q <= ST_NOT_FOUND;
						resp_q   <= 1'b1;
					end else begin
						lvl_q <= lvl_q + LW'(1);
						k_q   <= '0;
					end
				end
				S_QCMP: begin
					if (cmp_eq) begin
						state_q <= S_SRD;
					end else begin
						k_q     <= k_inc;
						state_q <= S_QSEL;
					end
				end
				S_SRD: begin
					if (k_inc < cnt_sel) begin
						state_q <= S_SWR;
					end else begin
						cnt_q[lvl_q] <= cnt_sel - CW'(1);
						res_id_q     <= tid_q;
						res_st_q     <= ST_OK;
						resp_q       <= 1'b1;
					end
				end
				S_SWR: begin
					k_q     <= k_inc;
					state_q <= S_SRD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_q && (!out_valid_q || m_axis_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_q && (!out_valid_q || m_axis_tready)) begin
			out_id_q <= res_id_q;
			out_st_q <= res_st_q;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE) && !resp_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_id_q;
	assign m_axis_tuser  = out_st_q;

endmodule

>>> rtl/core/ptq_checker.sv
// -----------------------------------------------------------------------------
// Priority task queue checker
// Port-level assertions on request and response behavior, bound to the top.
// -----------------------------------------------------------------------------
`include "priority_task_queue_with_cancel_defines.svh"

module ptq_checker import ptq_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [S_TDATA_W-1:0] s_axis_tdata,  // prio[3:0], task_id[35:4], zero[39:36]
	input logic [OP_W-1:0]      s_axis_tuser,  // op[2:0]
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata,  // result_id[31:0]
	input logic [ST_W-1:0]      m_axis_tuser   // status[2:0]
);

	// Block takes no new request right after one is accepted
	`PTQ_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while still busy")

	// Stalled response stays put
	`PTQ_ASSERT_NEXT(a_resp_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled response changed")

	// Full level never issues an id
	`PTQ_ASSERT_SAME(a_full_zero_id, m_axis_tvalid && (m_axis_tuser == ST_FULL), m_axis_tdata == '0, "queue full response carries an id")

	// Failed dispatch returns no id
	`PTQ_ASSERT_SAME(a_nodisp_zero_id, m_axis_tvalid && (m_axis_tuser == ST_EMPTY || m_axis_tuser == ST_BUSY), m_axis_tdata == '0, "failed dispatch carries an id")

endmodule

bind priority_task_queue_with_cancel ptq_checker u_ptq_checker (.*);
